@@ rtl/core/hsp_pkg.sv @@
// shared types, constants and the arctangent table of the scope projection
package hsp_pkg;

  localparam int ITERS = 16;
  localparam logic [17:0] PI_Q16 = 18'd205887;
  localparam logic [24:0] RECIP_PI = 25'd21361458;
  localparam logic signed [19:0] HALF_PI_Q16 = 20'sd102944;
  localparam logic [16:0] GAIN_Q16 = 17'd107922;
  localparam logic [15:0] INV_GAIN_Q16 = 16'd39798;
  localparam logic [15:0] ROW_PITCH_RESET = 16'd2048;
  localparam logic [4:0] PIXEL_BYTES_RESET = 5'd4;

  typedef enum logic [1:0] {
    REG_ROW_PITCH = 2'd0,
    REG_PIXEL_BYTES = 2'd1
  } reg_idx_t;

  typedef struct packed {
    logic signed [15:0] rel_x;
    logic signed [15:0] rel_y;
    logic signed [15:0] rel_z;
  } in_t;

  typedef struct packed {
    logic [7:0] scope_col;
    logic [7:0] scope_row;
    logic hemisphere;
    logic [23:0] byte_offset;
  } out_t;

  typedef struct packed {
    logic hemi;
    logic zero;
    logic signed [19:0] phi;
    logic [32:0] c;
  } side_t;

  typedef struct packed {
    logic valid;
    logic signed [35:0] a;
    logic signed [35:0] b;
    logic signed [19:0] ang;
    side_t side;
  } vec_t;

  typedef struct packed {
    logic valid;
    logic [17:0] theta;
    logic [23:0] quo;
    side_t side;
  } div_t;

  typedef struct packed {
    logic valid;
    logic signed [25:0] a;
    logic signed [25:0] b;
    logic signed [19:0] ang;
    side_t side;
  } rot_t;

  typedef struct packed {
    logic valid;
    logic hemi;
    logic [7:0] col;
    logic [7:0] row;
  } pix_t;

  function automatic logic signed [19:0] hsp_atan(input logic [3:0] i);
    logic signed [19:0] r;
    unique case (i)
      4'd0: r = 20'sd51472;
      4'd1: r = 20'sd30385;
      4'd2: r = 20'sd16055;
      4'd3: r = 20'sd8150;
      4'd4: r = 20'sd4091;
      4'd5: r = 20'sd2047;
      4'd6: r = 20'sd1024;
      4'd7: r = 20'sd512;
      4'd8: r = 20'sd256;
      4'd9: r = 20'sd128;
      4'd10: r = 20'sd64;
      4'd11: r = 20'sd32;
      4'd12: r = 20'sd16;
      4'd13: r = 20'sd8;
      4'd14: r = 20'sd4;
      4'd15: r = 20'sd2;
      default: r = 20'sd0;
    endcase
    return r;
  endfunction

endpackage

@@ rtl/core/hsp_vec_cell.sv @@
// one vectoring micro-rotation of the cordic chain
module hsp_vec_cell import hsp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       en,
  input  logic [3:0] step,
  input  vec_t       prev,
  output vec_t       cur
);

  vec_t cur_next;

  always_comb begin
    cur_next = prev;
    if (prev.b >= 0) begin
      cur_next.a = prev.a + (prev.b >>> step);
      cur_next.b = prev.b - (prev.a >>> step);
      cur_next.ang = prev.ang + hsp_atan(step);
    end else begin
      cur_next.a = prev.a - (prev.b >>> step);
      cur_next.b = prev.b + (prev.a >>> step);
      cur_next.ang = prev.ang - hsp_atan(step);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur.valid <= 1'b0;
    end else if (en) begin
      cur <= cur_next;
    end
  end

endmodule

@@ rtl/core/hsp_div_cell.sv @@
// two-stage reciprocal division of the polar angle by pi into the radius
module hsp_div_cell import hsp_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  div_t prev,
  output div_t cur
);

  div_t est;
  div_t est_next;
  div_t cur_next;
  logic [42:0] prod;
  logic [41:0] back;
  logic [41:0] diff;

  // quotient estimate, low by at most one
  always_comb begin
    est_next = prev;
    prod = 43'(prev.theta) * 43'(RECIP_PI);
    est_next.quo = prod[41:18];
  end

  // remainder check and correction
  always_comb begin
    cur_next = est;
    back = 42'(est.quo) * 42'(PI_Q16);
    diff = {est.theta, 24'd0} - back;
    if (diff >= 42'(PI_Q16)) begin
      cur_next.quo = est.quo + 24'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      est.valid <= 1'b0;
      cur.valid <= 1'b0;
    end else if (en) begin
      est <= est_next;
      cur <= cur_next;
    end
  end

endmodule

@@ rtl/core/hsp_rot_cell.sv @@
// one rotation-mode micro-rotation of the cordic chain
module hsp_rot_cell import hsp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       en,
  input  logic [3:0] step,
  input  rot_t       prev,
  output rot_t       cur
);

  rot_t cur_next;

  always_comb begin
    cur_next = prev;
    if (prev.ang >= 0) begin
      cur_next.a = prev.a - (prev.b >>> step);
      cur_next.b = prev.b + (prev.a >>> step);
      cur_next.ang = prev.ang - hsp_atan(step);
    end else begin
      cur_next.a = prev.a + (prev.b >>> step);
      cur_next.b = prev.b - (prev.a >>> step);
      cur_next.ang = prev.ang + hsp_atan(step);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur.valid <= 1'b0;
    end else if (en) begin
      cur <= cur_next;
    end
  end

endmodule

@@ rtl/core/hemisphere_scope_projection_core.sv @@
// top level of the hemisphere scope projection pipeline
//
//   port group  dir  handshake           payload
//   in          in   in_valid/in_stall   in_data  (rel_x, rel_y, rel_z)
//   out         out  out_valid/out_stall out_data (col, row, hemisphere, offset)
//   cfg         in   cfg_valid/cfg_ready cfg_index, cfg_data
//
// one transaction per cycle while the output is not stalled; the path to out_valid runs
// through three 16-cell cordic chains and the two-stage radius divider in series
// synchronous reset empties the pipeline and loads the register defaults
// a stalled output parks one transaction in a skid register; in_stall
// follows that register and freezes the whole chain
module hemisphere_scope_projection_core import hsp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_t         in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_t        out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  logic [15:0] row_pitch;
  logic [4:0] pixel_bytes;
  logic en;
  logic skid_valid;
  out_t skid_data;

  vec_t v1 [ITERS+1];
  vec_t v2 [ITERS+1];
  div_t dv;
  div_t dv_out;
  rot_t mul;
  rot_t rt [ITERS+1];
  pix_t pix;

  vec_t v1_next;
  vec_t v2_next;
  div_t dv_next;
  rot_t mul_next;
  rot_t rt_next;
  pix_t pix_next;
  out_t item;
  logic push;
  logic signed [35:0] ax;
  logic signed [35:0] ay;
  logic [15:0] pz;
  logic [39:0] prod;
  logic signed [26:0] colq;
  logic signed [26:0] rowq;
  logic signed [25:0] cx;
  logic signed [25:0] cy;
  logic [24:0] off;

  assign en = !skid_valid;
  assign in_stall = skid_valid;
  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      row_pitch <= ROW_PITCH_RESET;
      pixel_bytes <= PIXEL_BYTES_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_ROW_PITCH) begin
        row_pitch <= cfg_data;
      end else if (cfg_index == REG_PIXEL_BYTES) begin
        pixel_bytes <= cfg_data[4:0];
      end
    end
  end

  // entry: pre-rotation and scaled |z|
  always_comb begin
    ax = {{4{in_data.rel_x[15]}}, in_data.rel_x, 16'd0};
    ay = {{4{in_data.rel_y[15]}}, in_data.rel_y, 16'd0};
    pz = in_data.rel_z[15] ? 16'(-in_data.rel_z) : 16'(in_data.rel_z);
    v1_next.valid = in_valid && !in_stall;
    v1_next.side.hemi = !in_data.rel_z[15];
    v1_next.side.zero = (in_data.rel_x == 16'sd0) && (in_data.rel_y == 16'sd0);
    v1_next.side.phi = 20'sd0;
    v1_next.side.c = 33'(pz) * 33'(GAIN_Q16);
    if (ax < 0) begin
      if (ay >= 0) begin
        v1_next.a = ay;
        v1_next.b = -ax;
        v1_next.ang = HALF_PI_Q16;
      end else begin
        v1_next.a = -ay;
        v1_next.b = ax;
        v1_next.ang = -HALF_PI_Q16;
      end
    end else begin
      v1_next.a = ax;
      v1_next.b = ay;
      v1_next.ang = 20'sd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1[0].valid <= 1'b0;
    end else if (en) begin
      v1[0] <= v1_next;
    end
  end

  for (genvar g = 0; g < ITERS; g++) begin : g_v1
    hsp_vec_cell u_cell (
      .clk(clk), .rst(rst), .en(en), .step(4'(g)), .prev(v1[g]), .cur(v1[g+1])
    );
  end

  // polar angle chain
  always_comb begin
    v2_next = v1[ITERS];
    v2_next.side.phi = v1[ITERS].ang;
    v2_next.a = 36'(v1[ITERS].side.c);
    v2_next.b = v1[ITERS].a;
    v2_next.ang = 20'sd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2[0].valid <= 1'b0;
    end else if (en) begin
      v2[0] <= v2_next;
    end
  end

  for (genvar g = 0; g < ITERS; g++) begin : g_v2
    hsp_vec_cell u_cell (
      .clk(clk), .rst(rst), .en(en), .step(4'(g)), .prev(v2[g]), .cur(v2[g+1])
    );
  end

  // radius divider
  always_comb begin
    dv_next.valid = v2[ITERS].valid;
    dv_next.side = v2[ITERS].side;
    dv_next.theta = (v2[ITERS].ang < 0) ? 18'd0 : v2[ITERS].ang[17:0];
    dv_next.quo = 24'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dv.valid <= 1'b0;
    end else if (en) begin
      dv <= dv_next;
    end
  end

  hsp_div_cell u_div (
    .clk(clk), .rst(rst), .en(en), .prev(dv), .cur(dv_out)
  );

  // gain compensation
  always_comb begin
    prod = 40'(dv_out.quo) * 40'(INV_GAIN_Q16);
    mul_next.valid = dv_out.valid;
    mul_next.side = dv_out.side;
    mul_next.a = 26'({2'b00, prod[39:16]});
    mul_next.b = 26'sd0;
    mul_next.ang = dv_out.side.phi;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mul.valid <= 1'b0;
    end else if (en) begin
      mul <= mul_next;
    end
  end

  // quadrant fold before rotation
  always_comb begin
    rt_next = mul;
    if (mul.ang > HALF_PI_Q16) begin
      rt_next.a = 26'sd0;
      rt_next.b = mul.a;
      rt_next.ang = mul.ang - HALF_PI_Q16;
    end else if (mul.ang < -HALF_PI_Q16) begin
      rt_next.a = 26'sd0;
      rt_next.b = -mul.a;
      rt_next.ang = mul.ang + HALF_PI_Q16;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rt[0].valid <= 1'b0;
    end else if (en) begin
      rt[0] <= rt_next;
    end
  end

  for (genvar g = 0; g < ITERS; g++) begin : g_rot
    hsp_rot_cell u_cell (
      .clk(clk), .rst(rst), .en(en), .step(4'(g)), .prev(rt[g]), .cur(rt[g+1])
    );
  end

  // pixel position with saturation
  always_comb begin
    cx = rt[ITERS].side.zero ? 26'sd0 : rt[ITERS].a;
    cy = rt[ITERS].side.zero ? 26'sd0 : rt[ITERS].b;
    colq = 27'sd8388608 + 27'(cx);
    rowq = 27'sd8388608 - 27'(cy);
    pix_next.valid = rt[ITERS].valid;
    pix_next.hemi = rt[ITERS].side.hemi;
    if (colq < 0) begin
      pix_next.col = 8'd0;
    end else if (colq[26:24] != 3'd0) begin
      pix_next.col = 8'd255;
    end else begin
      pix_next.col = colq[23:16];
    end
    if (rowq < 0) begin
      pix_next.row = 8'd0;
    end else if (rowq[26:24] != 3'd0) begin
      pix_next.row = 8'd255;
    end else begin
      pix_next.row = rowq[23:16];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pix.valid <= 1'b0;
    end else if (en) begin
      pix <= pix_next;
    end
  end

  // byte offset and output register with skid
  always_comb begin
    off = 25'(pix.row) * 25'(row_pitch) + 25'({pix.hemi, pix.col}) * 25'(pixel_bytes);
    item.scope_col = pix.col;
    item.scope_row = pix.row;
    item.hemisphere = pix.hemi;
    item.byte_offset = off[23:0];
    push = en && pix.valid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (!out_stall) begin
        out_data <= skid_data;
        skid_valid <= 1'b0;
      end
    end else if (!out_valid || !out_stall) begin
      out_valid <= push;
      out_data <= item;
    end else if (push) begin
      skid_data <= item;
      skid_valid <= 1'b1;
    end
  end

endmodule

@@ rtl/core/hsp_checker.sv @@
// port-level checks of the scope projection core, bound to the top level
module hsp_checker import hsp_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input out_t        out_data,
  input logic        cfg_ready
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled output transaction changed");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("pipeline not empty after reset");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(in_stall) |-> $past(out_valid && out_stall))
    else $error("input stalled without a stalled output");

  a_cfg_ready: assert property (@(posedge clk) disable iff (rst)
    cfg_ready)
    else $error("config port not ready");

endmodule

bind hemisphere_scope_projection_core hsp_checker u_hsp_checker (.*);

@@ test/testbench.sv @@
// testbench for the hemisphere scope projection core: directed and random positions
`timescale 1ns / 100ps
module testbench;
  import hsp_pkg::*;

  localparam logic [1:0] REG_SPARE_LO = 2'd2;
  localparam logic [1:0] REG_SPARE_HI = 2'd3;
  localparam int SETTLE_CYCLES = 100;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam longint ARCTAN_Q16 [16] = '{51472, 30385, 16055, 8150, 4091, 2047, 1024, 512,
                                         256, 128, 64, 32, 16, 8, 4, 2};

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;

  out_t expected_blips[$];
  longint unsigned row_pitch = 2048;
  longint unsigned pix_bytes = 4;
  int fail_count = 0;
  bit quiet = 1'b0;
  int idle_cycles = 0;

  hemisphere_scope_projection_core u_top (.*);

  always #5 clk = ~clk;

  function automatic void vectoring(inout longint a, inout longint b, inout longint ang);
    longint na, nb;
    for (int i = 0; i < 16; i++) begin
      if (b >= 0) begin
        na = a + (b >>> i);
        nb = b - (a >>> i);
        ang += ARCTAN_Q16[i];
      end else begin
        na = a - (b >>> i);
        nb = b + (a >>> i);
        ang -= ARCTAN_Q16[i];
      end
      a = na;
      b = nb;
    end
  endfunction

  function automatic void rotation(inout longint a, inout longint b, input longint ang);
    longint na, nb;
    for (int i = 0; i < 16; i++) begin
      if (ang >= 0) begin
        na = a - (b >>> i);
        nb = b + (a >>> i);
        ang -= ARCTAN_Q16[i];
      end else begin
        na = a + (b >>> i);
        nb = b - (a >>> i);
        ang += ARCTAN_Q16[i];
      end
      a = na;
      b = nb;
    end
  endfunction

  function automatic longint unsigned to_pixel(longint q);
    longint p;
    if (q < 0) return 0;
    p = q >>> 16;
    return (p > 255) ? 255 : p;
  endfunction

  function automatic out_t project(in_t p);
    longint x, y, z, pz, a, b, phi, c, d, theta, rad, v, ra, rb, t, cx, cy;
    longint unsigned col, row, off, hemi;
    out_t r;
    x = p.rel_x;
    y = p.rel_y;
    z = p.rel_z;
    hemi = (z >= 0) ? 1 : 0;
    pz = (z < 0) ? -z : z;
    cx = 0;
    cy = 0;
    if (x != 0 || y != 0) begin
      a = x * 65536;
      b = y * 65536;
      phi = 0;
      if (a < 0) begin
        t = a;
        if (b >= 0) begin
          a = b; b = -t; phi = 102944;
        end else begin
          a = -b; b = t; phi = -102944;
        end
      end
      vectoring(a, b, phi);
      c = pz * 107922;
      d = a;
      theta = 0;
      vectoring(c, d, theta);
      if (theta < 0) theta = 0;
      rad = (theta * 256 * 65536) / 205887;
      v = (rad * 39798) >>> 16;
      if (phi > 102944) begin
        ra = 0; rb = v; phi -= 102944;
      end else if (phi < -102944) begin
        ra = 0; rb = -v; phi += 102944;
      end else begin
        ra = v; rb = 0;
      end
      rotation(ra, rb, phi);
      cx = ra;
      cy = rb;
    end
    col = to_pixel(128 * 65536 + cx);
    row = to_pixel(128 * 65536 - cy);
    off = row * row_pitch + (col + 256 * hemi) * pix_bytes;
    r.scope_col = col[7:0];
    r.scope_row = row[7:0];
    r.hemisphere = hemi[0];
    r.byte_offset = off[23:0];
    return r;
  endfunction

  // output stall bursts
  int stall_left = 0;
  always @(posedge clk) begin
    if (quiet || rst) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(0, 4);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // compare each result transaction with the oldest prediction
  always @(posedge clk) begin
    out_t exp_blip;
    if (!rst && out_valid && !out_stall) begin
      if (expected_blips.size() == 0) begin
        $error("unexpected result transaction %h", out_data);
        fail_count++;
      end else begin
        exp_blip = expected_blips.pop_front();
        if (out_data.scope_col !== exp_blip.scope_col) begin
          $error("scope_col expected %0d actual %0d", exp_blip.scope_col, out_data.scope_col);
          fail_count++;
        end
        if (out_data.scope_row !== exp_blip.scope_row) begin
          $error("scope_row expected %0d actual %0d", exp_blip.scope_row, out_data.scope_row);
          fail_count++;
        end
        if (out_data.hemisphere !== exp_blip.hemisphere) begin
          $error("hemisphere expected %0d actual %0d", exp_blip.hemisphere,
                 out_data.hemisphere);
          fail_count++;
        end
        if (out_data.byte_offset !== exp_blip.byte_offset) begin
          $error("byte_offset expected %0d actual %0d", exp_blip.byte_offset,
                 out_data.byte_offset);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  task automatic send_position(input in_t pos);
    int gap;
    gap = 0;
    if (!quiet && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 5);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= pos;
    do @(posedge clk); while (in_stall);
    expected_blips = {expected_blips, project(pos)};
  endtask

  task automatic send_xyz(input int x, input int y, input int z);
    in_t pos;
    pos.rel_x = x[15:0];
    pos.rel_y = y[15:0];
    pos.rel_z = z[15:0];
    send_position(pos);
  endtask

  task automatic drain_pipeline();
    in_valid <= 1'b0;
    while (expected_blips.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic [1:0] idx, input logic [15:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_ROW_PITCH) row_pitch = value;
    else if (idx == REG_PIXEL_BYTES) pix_bytes = value[4:0];
  endtask

  task automatic send_random_position();
    int x, y, z;
    x = $urandom_range(0, 65535) - 32768;
    y = $urandom_range(0, 65535) - 32768;
    z = $urandom_range(0, 65535) - 32768;
    case ($urandom_range(0, 5))
      0: begin
        x = $urandom_range(0, 40) - 20;
        y = $urandom_range(0, 40) - 20;
        z = $urandom_range(0, 40) - 20;
      end
      1: z = 0;
      2: begin
        x = 0;
        y = 0;
      end
      3: if ($urandom_range(0, 1)) x = 0; else y = 0;
      default: ;
    endcase
    send_xyz(x, y, z);
  endtask

  task automatic test_directed();
    send_xyz(0, 0, 0);
    send_xyz(0, 0, -1);
    send_xyz(0, 0, 32767);
    send_xyz(0, 0, -32768);
    send_xyz(32767, 0, 0);
    send_xyz(-32768, 0, 0);
    send_xyz(0, 32767, 0);
    send_xyz(0, -32768, 0);
    send_xyz(-32768, -32768, 0);
    send_xyz(32767, 32767, 0);
    send_xyz(-32768, 32767, -1);
    send_xyz(32767, -32768, -32768);
    send_xyz(1, 0, 0);
    send_xyz(-1, 0, 0);
    send_xyz(0, 1, 0);
    send_xyz(0, -1, 0);
    send_xyz(-1, -1, -1);
    send_xyz(100, 100, 100);
    send_xyz(-100, 100, -100);
    send_xyz(-100, -100, 100);
    send_xyz(1, 1, -32768);
    send_xyz(-32768, -32768, -32768);
    send_xyz(32767, 32767, 32767);
    drain_pipeline();
  endtask

  task automatic test_register_settings();
    logic [1:0] idx [6] = '{REG_ROW_PITCH, REG_PIXEL_BYTES, REG_ROW_PITCH, REG_PIXEL_BYTES,
                             REG_SPARE_LO, REG_SPARE_HI};
    logic [15:0] vals [6] = '{16'd1, 16'd1, 16'd65535, 16'd16, 16'hffff, 16'h1234};
    for (int s = 0; s < 6; s++) begin
      write_register(idx[s], vals[s]);
      repeat (60) send_random_position();
      drain_pipeline();
    end
    write_register(REG_ROW_PITCH, 16'd0);
    write_register(REG_PIXEL_BYTES, 16'd0);
    repeat (40) send_random_position();
    drain_pipeline();
    write_register(REG_PIXEL_BYTES, 16'hffff);
    repeat (40) send_random_position();
    drain_pipeline();
    write_register(REG_ROW_PITCH, 16'd2048);
    write_register(REG_PIXEL_BYTES, 16'd4);
  endtask

  task automatic test_random_traffic();
    repeat (600) send_random_position();
  endtask

  task automatic test_sender_pause();
    repeat (50) send_random_position();
    in_valid <= 1'b0;
    while (expected_blips.size() != 0) @(posedge clk);
    repeat (200) send_random_position();
  endtask

  task automatic test_full_rate();
    quiet = 1'b1;
    repeat (350) send_random_position();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_register_settings();
    test_random_traffic();
    test_sender_pause();
    test_full_rate();
    drain_pipeline();
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/hsp_pkg.sv
rtl/core/hsp_vec_cell.sv
rtl/core/hsp_div_cell.sv
rtl/core/hsp_rot_cell.sv
rtl/core/hemisphere_scope_projection_core.sv
rtl/core/hsp_checker.sv
test/testbench.sv
